>>> design/ahe_pkg.sv
// Adaptive Huffman encoder: shared package.
// Holds the controller command codes, the datapath status struct and fixed widths.
// No dependencies.
package ahe_pkg;

  localparam int SYM_W         = 9;
  localparam int CODE_W        = 32;
  localparam int CLEN_W        = 6;
  localparam int MAX_CODE_BITS = 288;
  localparam int LEN_W         = 9;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_INIT,
    CMD_LOAD,
    CMD_START,
    CMD_PATH_RD,
    CMD_PATH_RIGHT,
    CMD_PATH_BIT,
    CMD_UPD,
    CMD_SPLIT_A,
    CMD_SPLIT_B,
    CMD_SPLIT_Q,
    CMD_INC_RD,
    CMD_INC_WR,
    CMD_CL_RD,
    CMD_FP_INIT,
    CMD_POP,
    CMD_NODE_RD,
    CMD_VISIT,
    CMD_PUSH_L,
    CMD_SWAP_RD,
    CMD_SWAP_RD2,
    CMD_SWAP_W1,
    CMD_SWAP_W2,
    CMD_EMIT_SHIFT
  } cmd_t;

  typedef struct packed {
    logic sym_ok;
    logic path_done;
    logic is_new;
    logic room;
    logic q_root;
    logic climb_done;
    logic sp_zero;
    logic node_bad;
    logic push;
    logic best_zero;
    logic rem_zero;
    logic last;
  } stat_t;

endpackage

>>> design/ahe_ram.sv
// Adaptive Huffman encoder: generic single-write, single-read RAM.
// Read data registered, read-first on a colliding write. No dependencies.
module ahe_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/ahe_ctrl.sv
// Adaptive Huffman encoder: controller state machine.
// Sequences the datapath by commands; depends on ahe_pkg.
module ahe_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output ahe_pkg::cmd_t  cmd,
  input  ahe_pkg::stat_t st
);
  import ahe_pkg::*;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_START, S_PW_P, S_PW_R, S_PW_B, S_UPD,
    S_SP_A, S_SP_B, S_SP_Q, S_INC_RD, S_INC_WR, S_CL_CHK, S_CL_LAT,
    S_FP_POP, S_FP_NODE, S_FP_VIS, S_FP_PUSH, S_FP_END,
    S_SW_R2, S_SW_W1, S_SW_W2, S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_EMIT) && !st.rem_zero;

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NOP;
    unique case (state_r)
      S_INIT: begin
        cmd       = CMD_INIT;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd = CMD_LOAD;
          if (st.sym_ok) begin
            state_nxt = S_START;
          end
        end
      end
      S_START: begin
        cmd       = CMD_START;
        state_nxt = S_PW_P;
      end
      S_PW_P: begin
        cmd       = CMD_PATH_RD;
        state_nxt = st.path_done ? S_UPD : S_PW_R;
      end
      S_PW_R: begin
        cmd       = CMD_PATH_RIGHT;
        state_nxt = S_PW_B;
      end
      S_PW_B: begin
        cmd       = CMD_PATH_BIT;
        state_nxt = S_PW_P;
      end
      S_UPD: begin
        cmd = CMD_UPD;
        if (st.is_new) begin
          state_nxt = st.room ? S_SP_A : S_EMIT;
        end else begin
          state_nxt = S_INC_RD;
        end
      end
      S_SP_A: begin
        cmd       = CMD_SPLIT_A;
        state_nxt = S_SP_B;
      end
      S_SP_B: begin
        cmd       = CMD_SPLIT_B;
        state_nxt = S_SP_Q;
      end
      S_SP_Q: begin
        cmd       = CMD_SPLIT_Q;
        state_nxt = st.q_root ? S_EMIT : S_INC_RD;
      end
      S_INC_RD: begin
        cmd       = CMD_INC_RD;
        state_nxt = S_INC_WR;
      end
      S_INC_WR: begin
        cmd       = CMD_INC_WR;
        state_nxt = S_CL_CHK;
      end
      S_CL_CHK: begin
        cmd       = CMD_CL_RD;
        state_nxt = st.climb_done ? S_EMIT : S_CL_LAT;
      end
      S_CL_LAT: begin
        cmd       = CMD_FP_INIT;
        state_nxt = S_FP_POP;
      end
      S_FP_POP: begin
        if (st.sp_zero) begin
          state_nxt = S_FP_END;
        end else begin
          cmd       = CMD_POP;
          state_nxt = S_FP_NODE;
        end
      end
      S_FP_NODE: begin
        cmd       = CMD_NODE_RD;
        state_nxt = st.node_bad ? S_FP_POP : S_FP_VIS;
      end
      S_FP_VIS: begin
        cmd       = CMD_VISIT;
        state_nxt = st.push ? S_FP_PUSH : S_FP_POP;
      end
      S_FP_PUSH: begin
        cmd       = CMD_PUSH_L;
        state_nxt = S_FP_POP;
      end
      S_FP_END: begin
        cmd       = CMD_SWAP_RD;
        state_nxt = st.best_zero ? S_INC_RD : S_SW_R2;
      end
      S_SW_R2: begin
        cmd       = CMD_SWAP_RD2;
        state_nxt = S_SW_W1;
      end
      S_SW_W1: begin
        cmd       = CMD_SWAP_W1;
        state_nxt = S_SW_W2;
      end
      S_SW_W2: begin
        cmd       = CMD_SWAP_W2;
        state_nxt = S_INC_RD;
      end
      S_EMIT: begin
        if (st.rem_zero) begin
          state_nxt = S_IDLE;
        end else if (!out_stall) begin
          cmd = CMD_EMIT_SHIFT;
          if (st.last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> design/ahe_dpath.sv
// Adaptive Huffman encoder: datapath with node tables, search stack and code buffer.
// Executes controller commands; depends on ahe_pkg and ahe_ram.
module ahe_dpath #(
  parameter int ALPHABET_SIZE = 257,
  parameter int LITERAL_BITS  = 9,
  parameter int ROOT_ORDER    = 514
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ahe_pkg::cmd_t                 cmd,
  output ahe_pkg::stat_t                st,
  input  logic [ahe_pkg::SYM_W-1:0]     in_sym,
  output logic [ahe_pkg::CODE_W-1:0]    out_code_chunk,
  output logic [ahe_pkg::CLEN_W-1:0]    out_chunk_len,
  output logic                          out_last
);
  import ahe_pkg::*;

  localparam int NC   = 2 * ALPHABET_SIZE + 1;
  localparam int NW   = $clog2(NC);
  localparam int NUW  = $clog2(NC + 1);
  localparam int SD   = NC + 2;
  localparam int SAW  = $clog2(SD);
  localparam int SPW  = $clog2(NC + 3);
  localparam int AW   = $clog2(ALPHABET_SIZE);
  localparam int OW   = $clog2(ROOT_ORDER + 2 * ALPHABET_SIZE + 1) + 1;
  localparam int GW   = $clog2(4 * NC + 1);
  localparam int CAP  = MAX_CODE_BITS - LITERAL_BITS;

  // node tables
  logic          wt_we, od_we, pa_we, lf_we, rt_we, lv_we, sk_we;
  logic [NW-1:0] wt_wa, od_wa, pa_wa, lf_wa, rt_wa;
  logic [NW-1:0] wt_ra, od_ra, pa_ra, lf_ra, rt_ra;
  logic [31:0]   wt_wd, wt_rd;
  logic [OW-1:0] od_wd, od_rd;
  logic [NW-1:0] pa_wd, pa_rd, lf_wd, lf_rd, rt_wd, rt_rd;
  logic [AW-1:0] lv_wa, lv_ra;
  logic [NW-1:0] lv_wd, lv_rd;
  logic [SAW-1:0] sk_wa, sk_ra;
  logic [NW-1:0] sk_wd, sk_rd;

  ahe_ram #(.W(32), .D(NC)) u_wt (.clk(clk), .we(wt_we), .waddr(wt_wa), .wdata(wt_wd),
                                  .raddr(wt_ra), .rdata(wt_rd));
  ahe_ram #(.W(OW), .D(NC)) u_od (.clk(clk), .we(od_we), .waddr(od_wa), .wdata(od_wd),
                                  .raddr(od_ra), .rdata(od_rd));
  ahe_ram #(.W(NW), .D(NC)) u_pa (.clk(clk), .we(pa_we), .waddr(pa_wa), .wdata(pa_wd),
                                  .raddr(pa_ra), .rdata(pa_rd));
  ahe_ram #(.W(NW), .D(NC)) u_lf (.clk(clk), .we(lf_we), .waddr(lf_wa), .wdata(lf_wd),
                                  .raddr(lf_ra), .rdata(lf_rd));
  ahe_ram #(.W(NW), .D(NC)) u_rt (.clk(clk), .we(rt_we), .waddr(rt_wa), .wdata(rt_wd),
                                  .raddr(rt_ra), .rdata(rt_rd));
  ahe_ram #(.W(NW), .D(ALPHABET_SIZE)) u_lv (.clk(clk), .we(lv_we), .waddr(lv_wa),
                                  .wdata(lv_wd), .raddr(lv_ra), .rdata(lv_rd));
  ahe_ram #(.W(NW), .D(SD)) u_sk (.clk(clk), .we(sk_we), .waddr(sk_wa), .wdata(sk_wd),
                                  .raddr(sk_ra), .rdata(sk_rd));

  // registers
  logic [SYM_W-1:0]         sym_r, sym_nxt;
  logic                     hit_r, hit_nxt;
  logic                     is_new_r, is_new_nxt;
  logic [NW-1:0]            tgt_r, tgt_nxt, x_r, x_nxt, p_r, p_nxt, y_r, y_nxt;
  logic [NW-1:0]            q_r, q_nxt, nyt_r, nyt_nxt, ex_r, ex_nxt, best_r, best_nxt;
  logic [NW-1:0]            nd_r, nd_nxt, lft_r, lft_nxt, pc_r, pc_nxt;
  logic                     xl_r, xl_nxt, cl_r, cl_nxt;
  logic [NUW-1:0]           nu_r, nu_nxt;
  logic [LEN_W-1:0]         pn_r, pn_nxt, len_r, len_nxt;
  logic [MAX_CODE_BITS-1:0] buf_r, buf_nxt;
  logic [31:0]              w_r, w_nxt;
  logic signed [OW-1:0]     o_r, o_nxt, hi_r, hi_nxt;
  logic [SPW-1:0]           sp_r, sp_nxt;
  logic [GW-1:0]            guard_r, guard_nxt;
  logic [ALPHABET_SIZE-1:0] vld_r, vld_nxt;

  logic signed [OW-1:0]     od_rds;
  logic [SPW-1:0]           sp_dec;
  logic [AW-1:0]            sym_idx, in_idx;
  logic [NW-1:0]            node_a, node_b, tgt;
  logic [CLEN_W-1:0]        clen;
  logic [MAX_CODE_BITS-1:0] lit_top;

  assign od_rds  = od_rd;
  assign sp_dec  = sp_r - SPW'(1);
  assign sym_idx = sym_r[AW-1:0];
  assign in_idx  = in_sym[AW-1:0];
  assign node_a  = NW'(nu_r);
  assign node_b  = NW'(nu_r + NUW'(1));
  assign tgt     = hit_r ? lv_rd : nyt_r;
  assign lit_top = {sym_r[LITERAL_BITS-1:0], {(MAX_CODE_BITS - LITERAL_BITS){1'b0}}};
  assign clen    = (len_r >= LEN_W'(CODE_W)) ? CLEN_W'(CODE_W) : len_r[CLEN_W-1:0];

  assign out_code_chunk = buf_r[MAX_CODE_BITS-1 -: CODE_W] >> (CLEN_W'(CODE_W) - clen);
  assign out_chunk_len  = clen;
  assign out_last       = st.last;

  always_comb begin
    st.sym_ok     = (in_sym < SYM_W'(ALPHABET_SIZE));
    st.path_done  = (x_r == '0) || (x_r >= NW'(NC)) || (pn_r == LEN_W'(CAP));
    st.is_new     = is_new_r;
    st.room       = (({1'b0, nu_r} + (NUW+1)'(2)) <= (NUW+1)'(NC));
    st.q_root     = (q_r == '0);
    st.climb_done = (x_r == '0) || (x_r >= NW'(NC)) || (guard_r >= GW'(4 * NC));
    st.sp_zero    = (sp_r == '0);
    st.node_bad   = (sk_rd >= NW'(NC));
    st.push       = (wt_rd >= w_r) && (lf_rd != '0) &&
                    (({1'b0, sp_r} + (SPW+1)'(2)) <= (SPW+1)'(NC + 2));
    st.best_zero  = (best_r == '0);
    st.rem_zero   = (len_r == '0);
    st.last       = (len_r <= LEN_W'(CODE_W));
  end

  always_comb begin
    wt_we = 1'b0; wt_wa = x_r; wt_wd = '0; wt_ra = x_r;
    od_we = 1'b0; od_wa = x_r; od_wd = '0; od_ra = x_r;
    pa_we = 1'b0; pa_wa = x_r; pa_wd = '0; pa_ra = x_r;
    lf_we = 1'b0; lf_wa = x_r; lf_wd = '0; lf_ra = x_r;
    rt_we = 1'b0; rt_wa = x_r; rt_wd = '0; rt_ra = x_r;
    lv_we = 1'b0; lv_wa = sym_idx; lv_wd = node_b; lv_ra = sym_idx;
    sk_we = 1'b0; sk_wa = sp_r[SAW-1:0]; sk_wd = '0; sk_ra = sp_dec[SAW-1:0];

    sym_nxt = sym_r; hit_nxt = hit_r; is_new_nxt = is_new_r;
    tgt_nxt = tgt_r; x_nxt = x_r; p_nxt = p_r; y_nxt = y_r; q_nxt = q_r;
    nyt_nxt = nyt_r; ex_nxt = ex_r; best_nxt = best_r; nd_nxt = nd_r;
    lft_nxt = lft_r; pc_nxt = pc_r; xl_nxt = xl_r; cl_nxt = cl_r; nu_nxt = nu_r;
    pn_nxt = pn_r; len_nxt = len_r; buf_nxt = buf_r; w_nxt = w_r; o_nxt = o_r;
    hi_nxt = hi_r; sp_nxt = sp_r; guard_nxt = guard_r; vld_nxt = vld_r;

    unique case (cmd)
      CMD_NOP: begin
      end
      CMD_INIT: begin
        wt_we = 1'b1; wt_wa = '0;
        od_we = 1'b1; od_wa = '0; od_wd = OW'(ROOT_ORDER);
        pa_we = 1'b1; pa_wa = '0;
        lf_we = 1'b1; lf_wa = '0;
        rt_we = 1'b1; rt_wa = '0;
      end
      CMD_LOAD: begin
        sym_nxt = in_sym;
        lv_ra   = in_idx;
        hit_nxt = st.sym_ok && vld_r[in_idx];
      end
      CMD_START: begin
        is_new_nxt = !hit_r;
        tgt_nxt    = tgt;
        x_nxt      = tgt;
        pn_nxt     = '0;
        len_nxt    = hit_r ? '0 : LEN_W'(LITERAL_BITS);
        buf_nxt    = hit_r ? '0 : lit_top;
      end
      CMD_PATH_RD: begin
        pa_ra = x_r;
      end
      CMD_PATH_RIGHT: begin
        p_nxt = pa_rd;
        rt_ra = pa_rd;
      end
      CMD_PATH_BIT: begin
        buf_nxt = {(rt_rd == x_r), buf_r[MAX_CODE_BITS-1:1]};
        pn_nxt  = pn_r + LEN_W'(1);
        len_nxt = len_r + LEN_W'(1);
        x_nxt   = p_r;
      end
      CMD_UPD: begin
        y_nxt     = tgt_r;
        q_nxt     = nyt_r;
        od_ra     = nyt_r;
        pa_ra     = nyt_r;
        guard_nxt = '1;
      end
      CMD_SPLIT_A: begin
        o_nxt = od_rds;
        p_nxt = pa_rd;
        wt_we = 1'b1; wt_wa = node_a; wt_wd = '0;
        od_we = 1'b1; od_wa = node_a; od_wd = od_rd - OW'(2);
        pa_we = 1'b1; pa_wa = node_a; pa_wd = q_r;
        lf_we = 1'b1; lf_wa = node_a;
        rt_we = 1'b1; rt_wa = node_a;
      end
      CMD_SPLIT_B: begin
        wt_we = 1'b1; wt_wa = node_b; wt_wd = 32'd1;
        od_we = 1'b1; od_wa = node_b; od_wd = o_r - OW'(1);
        pa_we = 1'b1; pa_wa = node_b; pa_wd = q_r;
        lf_we = 1'b1; lf_wa = node_b;
        rt_we = 1'b1; rt_wa = node_b;
        lv_we = 1'b1;
        vld_nxt[sym_idx] = 1'b1;
      end
      CMD_SPLIT_Q: begin
        wt_we   = 1'b1; wt_wa = q_r; wt_wd = 32'd1;
        lf_we   = 1'b1; lf_wa = q_r; lf_wd = node_a;
        rt_we   = 1'b1; rt_wa = q_r; rt_wd = node_b;
        nyt_nxt = node_a;
        nu_nxt  = nu_r + NUW'(2);
        y_nxt   = p_r;
      end
      CMD_INC_RD: begin
        wt_ra = y_r;
      end
      CMD_INC_WR: begin
        wt_we     = 1'b1; wt_wa = y_r; wt_wd = wt_rd + 32'd1;
        x_nxt     = y_r;
        guard_nxt = guard_r + GW'(1);
      end
      CMD_CL_RD: begin
        wt_ra = x_r;
        od_ra = x_r;
        pa_ra = x_r;
      end
      CMD_FP_INIT: begin
        w_nxt    = wt_rd;
        o_nxt    = od_rds;
        ex_nxt   = pa_rd;
        best_nxt = '0;
        hi_nxt   = '0;
        sk_we    = 1'b1; sk_wa = '0; sk_wd = '0;
        sp_nxt   = SPW'(1);
      end
      CMD_POP: begin
        sk_ra  = sp_dec[SAW-1:0];
        sp_nxt = sp_dec;
      end
      CMD_NODE_RD: begin
        nd_nxt = sk_rd;
        wt_ra  = sk_rd;
        od_ra  = sk_rd;
        lf_ra  = sk_rd;
        rt_ra  = sk_rd;
      end
      CMD_VISIT: begin
        if ((nd_r != '0) && (nd_r != ex_r) && (wt_rd < w_r) && (od_rds > o_r) &&
            (od_rds > hi_r)) begin
          best_nxt = nd_r;
          hi_nxt   = od_rds;
        end
        if (st.push) begin
          sk_we   = 1'b1; sk_wa = sp_r[SAW-1:0]; sk_wd = rt_rd;
          sp_nxt  = sp_r + SPW'(1);
          lft_nxt = lf_rd;
        end
      end
      CMD_PUSH_L: begin
        sk_we  = 1'b1; sk_wa = sp_r[SAW-1:0]; sk_wd = lft_r;
        sp_nxt = sp_r + SPW'(1);
      end
      CMD_SWAP_RD: begin
        y_nxt = ex_r;
        pa_ra = best_r;
        lf_ra = ex_r;
      end
      CMD_SWAP_RD2: begin
        pc_nxt = pa_rd;
        xl_nxt = (lf_rd == x_r);
        lf_ra  = pa_rd;
      end
      CMD_SWAP_W1: begin
        cl_nxt = (lf_rd == best_r);
        od_we  = 1'b1; od_wa = x_r; od_wd = hi_r;
        if (xl_r) begin
          lf_we = 1'b1; lf_wa = ex_r; lf_wd = best_r;
        end else begin
          rt_we = 1'b1; rt_wa = ex_r; rt_wd = best_r;
        end
        pa_we = 1'b1; pa_wa = x_r; pa_wd = pc_r;
      end
      CMD_SWAP_W2: begin
        od_we = 1'b1; od_wa = best_r; od_wd = o_r;
        if (cl_r) begin
          lf_we = 1'b1; lf_wa = pc_r; lf_wd = x_r;
        end else begin
          rt_we = 1'b1; rt_wa = pc_r; rt_wd = x_r;
        end
        pa_we = 1'b1; pa_wa = best_r; pa_wd = ex_r;
        y_nxt = pc_r;
      end
      CMD_EMIT_SHIFT: begin
        buf_nxt = buf_r << CODE_W;
        len_nxt = len_r - LEN_W'(clen);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nyt_r <= '0;
      nu_r  <= NUW'(1);
      vld_r <= '0;
      len_r <= '0;
      sp_r  <= '0;
    end else begin
      nyt_r <= nyt_nxt;
      nu_r  <= nu_nxt;
      vld_r <= vld_nxt;
      len_r <= len_nxt;
      sp_r  <= sp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r    <= sym_nxt;
    hit_r    <= hit_nxt;
    is_new_r <= is_new_nxt;
    tgt_r    <= tgt_nxt;
    x_r      <= x_nxt;
    p_r      <= p_nxt;
    y_r      <= y_nxt;
    q_r      <= q_nxt;
    ex_r     <= ex_nxt;
    best_r   <= best_nxt;
    nd_r     <= nd_nxt;
    lft_r    <= lft_nxt;
    pc_r     <= pc_nxt;
    xl_r     <= xl_nxt;
    cl_r     <= cl_nxt;
    pn_r     <= pn_nxt;
    buf_r    <= buf_nxt;
    w_r      <= w_nxt;
    o_r      <= o_nxt;
    hi_r     <= hi_nxt;
    guard_r  <= guard_nxt;
  end

  a_nu_odd: assert property (@(posedge clk) disable iff (!rst_n) nu_r[0])
    else $error("node count lost its odd parity");
  a_nyt_alloc: assert property (@(posedge clk) disable iff (!rst_n) NUW'(nyt_r) < nu_r)
    else $error("NYT node outside allocated nodes");
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n) sp_r <= SPW'(NC + 2))
    else $error("search stack overrun");
  a_last_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_EMIT_SHIFT) && st.last |=> (len_r == '0))
    else $error("code bits left after final chunk");

endmodule

>>> design/adaptive_huffman_encoder_unit.sv
// Adaptive Huffman encoder, top level: controller plus datapath.
// Depends on ahe_pkg, ahe_ctrl, ahe_dpath (and ahe_ram through the datapath).
//
//   port group   dir  payload                                   handshake
//   in_          in   sym[8:0]                                  in_valid / in_stall
//   out_         out  code_chunk[31:0], chunk_len[5:0], last    out_valid / out_stall
//
// One request at a time. Path coding runs path, right and bit steps per tree level;
// each climb level updates a weight and runs the partner search (stack RAM walk), plus
// a swap if one is found; a new symbol adds the split steps. Chunks then leave one per
// cycle while out_stall is low. The root entry is written after reset, before the first
// request is taken. A stalled chunk holds; in_stall stays high until the last chunk goes.
module adaptive_huffman_encoder_unit #(
  parameter int ALPHABET_SIZE = 257,
  parameter int LITERAL_BITS  = 9,
  parameter int ROOT_ORDER    = 514
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [ahe_pkg::SYM_W-1:0]  in_sym,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [ahe_pkg::CODE_W-1:0] out_code_chunk,
  output logic [ahe_pkg::CLEN_W-1:0] out_chunk_len,
  output logic                       out_last
);
  import ahe_pkg::*;

  cmd_t  cmd;
  stat_t st;

  ahe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .st        (st)
  );

  ahe_dpath #(
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .LITERAL_BITS  (LITERAL_BITS),
    .ROOT_ORDER    (ROOT_ORDER)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .in_sym         (in_sym),
    .out_code_chunk (out_code_chunk),
    .out_chunk_len  (out_chunk_len),
    .out_last       (out_last)
  );

endmodule

>>> sim/adaptive_huffman_encoder_unit_tb.sv
// Testbench for adaptive_huffman_encoder_unit: random and directed symbol requests,
// predicted by an in-bench adaptive Huffman tree model and checked by a scoreboard class.
// Depends on ahe_pkg and the encoder RTL.
`timescale 1ns / 100ps

module adaptive_huffman_encoder_unit_tb;
  import ahe_pkg::*;

  localparam int ALPHA     = 257;
  localparam int LIT_BITS  = 9;
  localparam int ROOT_ORD  = 514;
  localparam int NODES     = 2 * ALPHA + 1;
  localparam int KIND_INT  = 510;
  localparam int KIND_NYT  = 511;
  localparam int N_SYMS    = 100;
  localparam longint LIMIT = 64'd200000000;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [CLEN_W-1:0] len;
    logic              last;
  } chunk_t;

  class code_scoreboard;
    logic [31:0] wt[NODES];
    int          ord[NODES];
    int          kind[NODES];
    int          par[NODES];
    int          lft[NODES];
    int          rgt[NODES];
    int          leaf_of[ALPHA];
    int          nyt;
    int          used;
    chunk_t      pending[$];
    int          errors;

    function void reset_tree();
      for (int i = 0; i < NODES; i++) begin
        wt[i] = 0; ord[i] = 0; kind[i] = 0; par[i] = 0; lft[i] = 0; rgt[i] = 0;
      end
      foreach (leaf_of[i]) leaf_of[i] = 0;
      ord[0] = ROOT_ORD;
      kind[0] = KIND_NYT;
      nyt = 0;
      used = 1;
      errors = 0;
    endfunction

    function int partner(int x);
      int stk[$];
      int n;
      int best;
      int hi;
      logic [31:0] w;
      best = 0;
      hi = 0;
      w = wt[x];
      stk.push_back(0);
      while (stk.size() > 0) begin
        n = stk.pop_back();
        if (n >= NODES) continue;
        if (n != 0 && n != par[x] && wt[n] < w && ord[n] > ord[x] && ord[n] > hi) begin
          best = n;
          hi = ord[n];
        end
        if (wt[n] >= w && lft[n] != 0) begin
          stk.push_back(rgt[n]);
          stk.push_back(lft[n]);
        end
      end
      return best;
    endfunction

    function void swap_pair(int x, int c);
      int px;
      int pc;
      bit xl;
      bit cl;
      int t;
      px = par[x];
      pc = par[c];
      xl = (lft[px] == x);
      cl = (lft[pc] == c);
      t = ord[x]; ord[x] = ord[c]; ord[c] = t;
      if (xl) lft[px] = c; else rgt[px] = c;
      if (cl) lft[pc] = x; else rgt[pc] = x;
      par[x] = pc;
      par[c] = px;
    endfunction

    function void climb(int x);
      int c;
      int g;
      g = 0;
      while (x != 0 && g < 4 * NODES) begin
        c = partner(x);
        if (c != 0) swap_pair(x, c);
        x = par[x];
        wt[x] = wt[x] + 1;
        g++;
      end
    endfunction

    // note an accepted request and queue its chunks
    function void note_request(logic [SYM_W-1:0] s);
      bit bits[$];
      bit rev[$];
      int lf;
      int x;
      int q;
      int a;
      int b;
      int nb;
      chunk_t ch;
      if (s >= ALPHA) return;
      lf = leaf_of[s];
      x = (lf == 0) ? nyt : lf;
      while (x != 0) begin
        rev.push_front(rgt[par[x]] == x);
        x = par[x];
      end
      bits = rev;
      if (lf == 0) begin
        q = nyt;
        for (int i = LIT_BITS - 1; i >= 0; i--) bits.push_back(s[i]);
        if (used + 2 <= NODES) begin
          a = used;
          b = used + 1;
          wt[a] = 0; ord[a] = ord[q] - 2; kind[a] = KIND_NYT; par[a] = q;
          lft[a] = 0; rgt[a] = 0;
          wt[b] = 1; ord[b] = ord[q] - 1; kind[b] = s; par[b] = q;
          lft[b] = 0; rgt[b] = 0;
          lft[q] = a; rgt[q] = b; kind[q] = KIND_INT; wt[q] = 1;
          leaf_of[s] = b;
          nyt = a;
          used += 2;
          if (q != 0) begin
            wt[par[q]] = wt[par[q]] + 1;
            climb(par[q]);
          end
        end
      end else begin
        wt[lf] = wt[lf] + 1;
        climb(lf);
      end
      for (int k = 0; k < bits.size(); k += 32) begin
        nb = bits.size() - k;
        if (nb > 32) nb = 32;
        ch.code = '0;
        for (int i = 0; i < nb; i++) ch.code = {ch.code[CODE_W-2:0], bits[k+i]};
        ch.len = CLEN_W'(nb);
        ch.last = (k + 32 >= bits.size());
        pending.push_back(ch);
      end
    endfunction

    function void check_chunk(chunk_t got);
      chunk_t exp_c;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected chunk %h len %0d last %b",
                                   got.code, got.len, got.last);
        return;
      end
      exp_c = pending.pop_front();
      if (got !== exp_c) begin
        errors++;
        if (errors <= 10)
          $display("chunk mismatch: exp %h/%0d/%b got %h/%0d/%b", exp_c.code, exp_c.len,
                   exp_c.last, got.code, got.len, got.last);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [SYM_W-1:0]  in_sym;
  logic              out_valid;
  logic              out_stall;
  logic [CODE_W-1:0] out_code_chunk;
  logic [CLEN_W-1:0] out_chunk_len;
  logic              out_last;

  code_scoreboard sb;
  longint         cycles;
  bit             hold_req;
  bit             sending_done;

  adaptive_huffman_encoder_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sym         (in_sym),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_chunk (out_code_chunk),
    .out_chunk_len  (out_chunk_len),
    .out_last       (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // valid stays high after acceptance until the next request decides
  task automatic send_sym(logic [SYM_W-1:0] s, bit quiet);
    int g;
    g = quiet ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sym   <= s;
    do @(posedge clk); while (in_stall);
    sb.note_request(s);
    @(negedge clk);
  endtask

  // sample results at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_chunk({out_code_chunk, out_chunk_len, out_last});
  end

  // receiver stalls
  initial begin
    int g;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (3000) @(negedge clk);
        hold_req = 1'b0;
      end
      g = sending_done ? 0 : gap_len();
      if (g > 0) begin
        out_stall <= 1'b1;
        repeat (g - 1) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    int r;
    int drain;
    sb = new();
    sb.reset_tree();
    hold_req = 1'b0;
    sending_done = 1'b0;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_sym   = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    // directed: first symbol, repeats, extremes, end marker, out-of-range
    send_sym(9'd0, 1'b1);
    send_sym(9'd0, 1'b0);
    send_sym(9'd255, 1'b0);
    send_sym(9'd256, 1'b0);
    send_sym(9'd257, 1'b0);
    send_sym(9'd511, 1'b0);
    send_sym(9'd170, 1'b0);
    send_sym(9'd85, 1'b0);
    send_sym(9'd255, 1'b0);
    send_sym(9'd0, 1'b0);
    send_sym(9'd256, 1'b0);
    send_sym(9'd1, 1'b0);
    hold_req = 1'b1;
    for (int i = 0; i < 6; i++) send_sym(SYM_W'($urandom_range(0, 256)), 1'b1);
    for (int i = 0; i < N_SYMS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55)      send_sym(SYM_W'($urandom_range(0, 15)), 1'b0);
      else if (r < 90) send_sym(SYM_W'($urandom_range(0, 256)), 1'b0);
      else if (r < 95) send_sym(SYM_W'($urandom_range(257, 511)), 1'b0);
      else             send_sym(9'd256, 1'b0);
    end
    // every other symbol, so long codes and wide trees appear
    for (int i = 0; i <= 256; i += 2) send_sym(SYM_W'(i), $urandom_range(0, 3) != 0);
    in_valid <= 1'b0;
    sending_done = 1'b1;
    while (sb.pending.size() > 0) @(posedge clk);
    drain = 0;
    while (drain < 2000) begin
      @(posedge clk);
      drain++;
    end
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
